// ===== rtl/sdspi_pkg.sv =====
`default_nettype none

package sdspi_pkg;

  localparam int SECTOR_BYTES = 512;

  // Request codes carried by the action field
  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_READ = 2'd1,
    ACT_BYTE = 2'd2,
    ACT_NOP  = 2'd3
  } action_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_DUMMY_COUNT = 2'd0,
    CFG_POLL_LIMIT  = 2'd1,
    CFG_RETRY_LIMIT = 2'd2,
    CFG_TOKEN_LIMIT = 2'd3
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CMD0_FAIL = 3'd1,
    ST_CMD8_FAIL = 3'd2,
    ST_ACMD_FAIL = 3'd3,
    ST_READ_FAIL = 3'd4,
    ST_TOKEN_TO  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DUMMY,
    PH_CMD,
    PH_R1,
    PH_TRAIL,
    PH_TOKEN,
    PH_DATA,
    PH_CRC
  } phase_t;

  // What goes out with the next exchange
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_IDLE,
    EMIT_FILL,
    EMIT_FRAME,
    EMIT_DONE
  } emit_t;

  localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
  localparam logic [5:0] CMD_SEND_IF   = 6'd8;
  localparam logic [5:0] CMD_READ_ONE  = 6'd17;
  localparam logic [5:0] CMD_APP       = 6'd55;
  localparam logic [5:0] CMD_SEND_OPC  = 6'd41;

  localparam logic [31:0] ARG_IF_COND = 32'h0000_01AA;
  localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

  localparam logic [7:0] BYTE_FILL  = 8'hFF;
  localparam logic [7:0] TOKEN_DATA = 8'hFE;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_ILLEGAL = 8'h05;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] CRC_CMD0   = 8'h95;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [1:0] CMD_START  = 2'b01;

  typedef struct packed {
    logic [7:0]  dummy_count;
    logic [7:0]  poll_limit;
    logic [11:0] retry_limit;
    logic [11:0] token_limit;
  } limits_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       done_res;
    logic [2:0] status;
    logic       fast_clock;
    logic       wait_request;
  } result_t;

  function automatic logic [47:0] make_frame(input logic [5:0] idx, input logic [31:0] arg);
    logic [7:0] chk;
    if (idx == CMD_GO_IDLE) begin
      chk = CRC_CMD0;
    end else if (idx == CMD_SEND_IF) begin
      chk = CRC_CMD8;
    end else begin
      chk = BYTE_FILL;
    end
    return {CMD_START, idx, arg, chk};
  endfunction

  function automatic logic [7:0] frame_byte(input logic [47:0] frame, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0: b = frame[47:40];
      3'd1: b = frame[39:32];
      3'd2: b = frame[31:24];
      3'd3: b = frame[23:16];
      3'd4: b = frame[15:8];
      3'd5: b = frame[7:0];
      default: b = BYTE_FILL;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sdspi_cfg.sv =====
`default_nettype none

module sdspi_cfg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [1:0]       wr_index,
  input  wire logic [11:0]      wr_data,
  output sdspi_pkg::limits_t    lim
);
  import sdspi_pkg::*;

  logic [7:0]  dummy_count_r;
  logic [7:0]  poll_limit_r;
  logic [11:0] retry_limit_r;
  logic [11:0] token_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dummy_count_r <= 8'd10;
      poll_limit_r  <= 8'd8;
      retry_limit_r <= 12'd1000;
      token_limit_r <= 12'd1000;
    end else if (wr_en) begin
      case (cfg_index_t'(wr_index))
        CFG_DUMMY_COUNT: dummy_count_r <= wr_data[7:0];
        CFG_POLL_LIMIT:  poll_limit_r  <= wr_data[7:0];
        CFG_RETRY_LIMIT: retry_limit_r <= wr_data;
        CFG_TOKEN_LIMIT: token_limit_r <= wr_data;
        default: ;
      endcase
    end
  end

  // A limit written as zero counts as one
  always_comb begin
    lim.dummy_count = (dummy_count_r == '0) ? 8'd1 : dummy_count_r;
    lim.poll_limit  = (poll_limit_r == '0) ? 8'd1 : poll_limit_r;
    lim.retry_limit = (retry_limit_r == '0) ? 12'd1 : retry_limit_r;
    lim.token_limit = (token_limit_r == '0) ? 12'd1 : token_limit_r;
  end

endmodule

`default_nettype wire

// ===== rtl/sdspi_seq.sv =====
`default_nettype none

module sdspi_seq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step,
  input  wire logic [1:0]       action,
  input  wire logic [31:0]      sector_address,
  input  wire logic [7:0]       rx_byte,
  input  wire sdspi_pkg::limits_t lim,
  output sdspi_pkg::result_t    res
);
  import sdspi_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [9:0]  byte_index_r, byte_index_nxt;
  logic [11:0] retry_count_r, retry_count_nxt;
  logic [11:0] poll_count_r, poll_count_nxt;
  logic [47:0] command_frame_r, command_frame_nxt;
  logic        fast_mode_r, fast_mode_nxt;

  emit_t       emit;
  status_t     status;
  logic        wait_req;
  logic        data_valid;
  logic        data_last;

  logic [9:0]  bidx_inc;
  logic [11:0] poll_inc;
  logic [11:0] retry_inc;
  logic [5:0]  cmd_idx;
  logic        r1_take;

  assign bidx_inc  = byte_index_r + 10'd1;
  assign poll_inc  = poll_count_r + 12'd1;
  assign retry_inc = retry_count_r + 12'd1;
  assign cmd_idx   = command_frame_r[45:40];
  assign r1_take   = !rx_byte[7] || (poll_inc >= {4'd0, lim.poll_limit});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      byte_index_r    <= '0;
      retry_count_r   <= '0;
      poll_count_r    <= '0;
      command_frame_r <= '0;
      fast_mode_r     <= 1'b0;
    end else if (step) begin
      phase_r         <= phase_nxt;
      byte_index_r    <= byte_index_nxt;
      retry_count_r   <= retry_count_nxt;
      poll_count_r    <= poll_count_nxt;
      command_frame_r <= command_frame_nxt;
      fast_mode_r     <= fast_mode_nxt;
    end
  end

  // Next state and the kind of exchange that follows
  always_comb begin
    phase_nxt         = phase_r;
    byte_index_nxt    = byte_index_r;
    retry_count_nxt   = retry_count_r;
    poll_count_nxt    = poll_count_r;
    command_frame_nxt = command_frame_r;
    fast_mode_nxt     = fast_mode_r;
    emit              = EMIT_NONE;
    status            = ST_OK;
    wait_req          = 1'b0;
    data_valid        = 1'b0;
    data_last         = 1'b0;
    case (action_t'(action))
      ACT_INIT: begin
        fast_mode_nxt   = 1'b0;
        byte_index_nxt  = '0;
        retry_count_nxt = '0;
        poll_count_nxt  = '0;
        phase_nxt       = PH_DUMMY;
        emit            = EMIT_IDLE;
      end
      ACT_READ: begin
        retry_count_nxt   = '0;
        poll_count_nxt    = '0;
        command_frame_nxt = make_frame(CMD_READ_ONE, sector_address);
        byte_index_nxt    = '0;
        phase_nxt         = PH_CMD;
        emit              = EMIT_FRAME;
      end
      ACT_BYTE: begin
        case (phase_r)
          PH_DUMMY: begin
            byte_index_nxt = bidx_inc;
            if (bidx_inc < {2'd0, lim.dummy_count}) begin
              emit = EMIT_IDLE;
            end else begin
              command_frame_nxt = make_frame(CMD_GO_IDLE, '0);
              byte_index_nxt    = '0;
              phase_nxt         = PH_CMD;
              emit              = EMIT_FRAME;
            end
          end
          PH_CMD: begin
            byte_index_nxt = bidx_inc;
            if (bidx_inc < 10'd6) begin
              emit = EMIT_FRAME;
            end else begin
              poll_count_nxt = '0;
              phase_nxt      = PH_R1;
              emit           = EMIT_FILL;
            end
          end
          PH_R1: begin
            poll_count_nxt = poll_inc;
            if (!r1_take) begin
              emit = EMIT_FILL;
            end else begin
              case (cmd_idx)
                CMD_GO_IDLE: begin
                  if (rx_byte != R1_IDLE) begin
                    phase_nxt = PH_IDLE;
                    emit      = EMIT_DONE;
                    status    = ST_CMD0_FAIL;
                  end else begin
                    command_frame_nxt = make_frame(CMD_SEND_IF, ARG_IF_COND);
                    byte_index_nxt    = '0;
                    phase_nxt         = PH_CMD;
                    emit              = EMIT_FRAME;
                  end
                end
                CMD_SEND_IF: begin
                  if (rx_byte == R1_IDLE) begin
                    phase_nxt      = PH_TRAIL;
                    byte_index_nxt = '0;
                    emit           = EMIT_FILL;
                  end else if (rx_byte == R1_ILLEGAL) begin
                    retry_count_nxt   = '0;
                    command_frame_nxt = make_frame(CMD_APP, '0);
                    byte_index_nxt    = '0;
                    phase_nxt         = PH_CMD;
                    emit              = EMIT_FRAME;
                  end else begin
                    phase_nxt = PH_IDLE;
                    emit      = EMIT_DONE;
                    status    = ST_CMD8_FAIL;
                  end
                end
                CMD_APP: begin
                  command_frame_nxt = make_frame(CMD_SEND_OPC, ARG_HCS);
                  byte_index_nxt    = '0;
                  phase_nxt         = PH_CMD;
                  emit              = EMIT_FRAME;
                end
                CMD_SEND_OPC: begin
                  if (rx_byte == R1_READY) begin
                    fast_mode_nxt = 1'b1;
                    phase_nxt     = PH_IDLE;
                    emit          = EMIT_DONE;
                  end else begin
                    retry_count_nxt = retry_inc;
                    if (retry_inc >= lim.retry_limit) begin
                      phase_nxt = PH_IDLE;
                      emit      = EMIT_DONE;
                      status    = ST_ACMD_FAIL;
                    end else begin
                      command_frame_nxt = make_frame(CMD_APP, '0);
                      byte_index_nxt    = '0;
                      phase_nxt         = PH_CMD;
                      emit              = EMIT_FRAME;
                      wait_req          = 1'b1;
                    end
                  end
                end
                default: begin
                  if (rx_byte != R1_READY) begin
                    phase_nxt = PH_IDLE;
                    emit      = EMIT_DONE;
                    status    = ST_READ_FAIL;
                  end else begin
                    phase_nxt      = PH_TOKEN;
                    poll_count_nxt = '0;
                    emit           = EMIT_FILL;
                  end
                end
              endcase
            end
          end
          PH_TRAIL: begin
            byte_index_nxt = bidx_inc;
            if (bidx_inc < 10'd4) begin
              emit = EMIT_FILL;
            end else begin
              retry_count_nxt   = '0;
              command_frame_nxt = make_frame(CMD_APP, '0);
              byte_index_nxt    = '0;
              phase_nxt         = PH_CMD;
              emit              = EMIT_FRAME;
            end
          end
          PH_TOKEN: begin
            if (rx_byte == TOKEN_DATA) begin
              phase_nxt      = PH_DATA;
              byte_index_nxt = '0;
              emit           = EMIT_FILL;
            end else begin
              poll_count_nxt = poll_inc;
              if (poll_inc >= lim.token_limit) begin
                phase_nxt = PH_IDLE;
                emit      = EMIT_DONE;
                status    = ST_TOKEN_TO;
              end else begin
                emit = EMIT_FILL;
              end
            end
          end
          PH_DATA: begin
            data_valid     = 1'b1;
            data_last      = byte_index_r >= 10'(SECTOR_BYTES - 1);
            byte_index_nxt = bidx_inc;
            emit           = EMIT_FILL;
            if (data_last) begin
              phase_nxt      = PH_CRC;
              byte_index_nxt = '0;
            end
          end
          PH_CRC: begin
            byte_index_nxt = bidx_inc;
            if (bidx_inc < 10'd2) begin
              emit = EMIT_FILL;
            end else begin
              phase_nxt = PH_IDLE;
              emit      = EMIT_DONE;
            end
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
      default: ;
    endcase
  end

  // Result fields
  always_comb begin
    res              = '0;
    res.fast_clock   = fast_mode_nxt;
    res.wait_request = wait_req;
    res.data_valid   = data_valid;
    res.data_last    = data_last;
    res.data_byte    = data_valid ? rx_byte : 8'd0;
    case (emit)
      EMIT_IDLE: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = BYTE_FILL;
      end
      EMIT_FILL: begin
        res.tx_valid  = 1'b1;
        res.tx_byte   = BYTE_FILL;
        res.cs_active = 1'b1;
      end
      EMIT_FRAME: begin
        res.tx_valid  = 1'b1;
        res.tx_byte   = frame_byte(command_frame_nxt, byte_index_nxt[2:0]);
        res.cs_active = 1'b1;
      end
      EMIT_DONE: begin
        res.done_res = 1'b1;
        res.status   = status;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/sd_spi_init_and_block_read.sv =====
// SD card host sequencer for SPI mode, advanced one exchanged byte per item. Send an item
// with action 0 to start card init (idle 0xFF bytes with select released, CMD0, CMD8 with
// its four trailing bytes, then CMD55/ACMD41 until the card is ready), or action 1 with a
// block address to read one 512-byte sector (CMD17, R1, wait for the 0xFE start token,
// 512 data bytes, 2 CRC bytes skipped). After every exchange on the SPI bus, send an item
// with action 2 and the received byte; each item yields exactly one result that says
// whether another exchange follows (tx_valid), which byte to shift out and whether select
// is held low for it. Sector bytes come out on data_byte/data_valid with data_last on the
// final one. done_res ends a request with its status; select is released on every finish.
// fast_clock rises after a successful init; wait_request asks for a pause before the next
// exchange of an ACMD41 retry. A new request abandons a running one. An item is taken
// every cycle but while the input stalls, which it does only when a result waits in the
// output register and out_stall is high: the whole step is one pass of small logic on
// the sequencer state. Configuration registers (0 idle byte count, 1 R1 poll limit, 2
// ACMD41 attempt limit, 3 start token wait limit; zero counts as one) are for the user
// to write while no request item is in flight; the block does not enforce it.
`default_nettype none

module sd_spi_init_and_block_read (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [31:0] in_sector_address,
  input  wire logic [7:0]  in_rx_byte,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_cs_active,
  output logic             out_data_valid,
  output logic [7:0]       out_data_byte,
  output logic             out_data_last,
  output logic             out_done_res,
  output logic [2:0]       out_status,
  output logic             out_fast_clock,
  output logic             out_wait_request,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);
  import sdspi_pkg::*;

  limits_t lim;
  result_t step_res;
  result_t result_r;
  logic    out_valid_r, out_valid_nxt;
  logic    step;

  // Registers take a write on any cycle
  assign cfg_ready = 1'b1;

  sdspi_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .lim      (lim)
  );

  // Hold input while the result register is full and the consumer stalls
  assign in_stall = out_valid_r && out_stall;
  assign step     = in_valid && !in_stall;

  sdspi_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .action         (in_action),
    .sector_address (in_sector_address),
    .rx_byte        (in_rx_byte),
    .lim            (lim),
    .res            (step_res)
  );

  // Result register: load on every accepted item, drop once taken
  assign out_valid_nxt = step || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= step_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tx_valid     = result_r.tx_valid;
  assign out_tx_byte      = result_r.tx_byte;
  assign out_cs_active    = result_r.cs_active;
  assign out_data_valid   = result_r.data_valid;
  assign out_data_byte    = result_r.data_byte;
  assign out_data_last    = result_r.data_last;
  assign out_done_res     = result_r.done_res;
  assign out_status       = result_r.status;
  assign out_fast_clock   = result_r.fast_clock;
  assign out_wait_request = result_r.wait_request;

`ifndef SYNTHESIS
  a_idle_tx_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_valid |-> out_tx_byte == 8'h00 && !out_cs_active)
    else $error("tx byte or select set without a following exchange");

  a_done_ends_bus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_tx_valid && !out_data_valid)
    else $error("finished request still asks for an exchange");

  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_status == ST_OK)
    else $error("status set on an unfinished request");

  a_data_selected: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data_valid |-> out_tx_valid && out_cs_active)
    else $error("sector byte delivered without a following exchange");

  a_wait_on_cmd55: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_wait_request |-> out_cs_active && out_tx_byte == {CMD_START, CMD_APP})
    else $error("pause requested outside an ACMD41 retry");
`endif

endmodule

`default_nettype wire
